@@ rtl/core/point_light_shading_factor_unit_macros.svh @@
// Assertion helpers shared by the shading pipeline.
`ifndef POINT_LIGHT_SHADING_FACTOR_UNIT_MACROS_SVH
`define POINT_LIGHT_SHADING_FACTOR_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define PLS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequence is checked in the cycle after the antecedent.
`define PLS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/core/pls_pkg.sv @@
package pls_pkg;
  localparam int unsigned CoordFracBits = 16;
  localparam int unsigned FifoDepth = 4;
  localparam logic [7:0] ChanMax = 8'd255;
  localparam logic [2:0] RegPosX = 3'd0;
  localparam logic [2:0] RegPosY = 3'd1;
  localparam logic [2:0] RegPosZ = 3'd2;
  localparam logic [2:0] RegIntensity = 3'd3;
  localparam logic [2:0] RegCutoff = 3'd4;
  localparam logic [2:0] RegSoftness = 3'd5;
  localparam logic [2:0] RegColor = 3'd6;
  localparam logic [2:0] RegDomains = 3'd7;

  // Classification of one item made in the front part.
  typedef enum logic [1:0] {
    KindBlack = 2'd0,
    KindFull  = 2'd1,
    KindLit   = 2'd2
  } kind_e;

  // One classified beat handed from front to back.
  typedef struct packed {
    kind_e        kind;
    logic [63:0]  sq;
    logic [48:0]  num;  // delta.n clamped at zero, nonnegative
  } work_t;

  typedef struct packed {
    logic [31:0] intensity;
    logic [16:0] softness;
    logic [23:0] color;
  } light_t;
endpackage

@@ rtl/core/point_light_shading_factor_unit.sv @@
// Point light shading: one surface point and normal in, the RGB contribution
// of one point light out, one beat per cycle in steady state. A front pipe of
// three stages forms the light-to-point delta, its squared length and the
// dot product with the normal, and classifies each beat as black (domain miss
// or at/after the cutoff), full color (zero distance) or lit. A four-entry
// queue decouples it from the back pipe, which runs a 32-stage square root,
// a 64-stage long division (two quotients in lockstep) and four stages of
// blend and scale. Throughput is one beat per cycle whenever the output side
// does not stall. An output stall freezes the back pipe; the queue then fills
// and the input side stalls once a beat waits in the last front stage.
module point_light_shading_factor_unit #(
  parameter int unsigned CoordFracBits = pls_pkg::CoordFracBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  input  logic signed [15:0] normal_x_i,
  input  logic signed [15:0] normal_y_i,
  input  logic signed [15:0] normal_z_i,
  input  logic               in_domain_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_red_o,
  output logic [7:0]         out_green_o,
  output logic [7:0]         out_blue_o
);
  import pls_pkg::*;

  // Configuration registers.
  logic signed [31:0] lx_q, ly_q, lz_q;
  logic [63:0] cut_q;
  logic use_dom_q;
  light_t light_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lx_q <= '0;
      ly_q <= '0;
      lz_q <= '0;
      cut_q <= 64'd16711680;
      use_dom_q <= 1'b0;
      light_q.intensity <= 32'd65536;
      light_q.softness <= '0;
      light_q.color <= 24'hFFFFFF;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegPosX: lx_q <= cfg_data_i[31:0];
        RegPosY: ly_q <= cfg_data_i[31:0];
        RegPosZ: lz_q <= cfg_data_i[31:0];
        RegIntensity: light_q.intensity <= cfg_data_i[31:0];
        RegCutoff: cut_q <= cfg_data_i;
        RegSoftness: light_q.softness <= cfg_data_i[16:0];
        RegColor: light_q.color <= cfg_data_i[23:0];
        RegDomains: use_dom_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic fv, fr, qv, qr;
  work_t fw, qw;

  pls_front u_front (
    .clk_i, .rst_ni,
    .valid_i(in_valid_i), .stall_o(in_stall_o),
    .lx_i(lx_q), .ly_i(ly_q), .lz_i(lz_q),
    .cutoff_i(cut_q), .use_dom_i(use_dom_q),
    .px_i(point_x_i), .py_i(point_y_i), .pz_i(point_z_i),
    .nx_i(normal_x_i), .ny_i(normal_y_i), .nz_i(normal_z_i),
    .dom_i(in_domain_i),
    .valid_o(fv), .ready_i(fr), .work_o(fw)
  );

  pls_fifo #(.Depth(FifoDepth)) u_fifo (
    .clk_i, .rst_ni,
    .valid_i(fv), .ready_o(fr), .data_i(fw),
    .valid_o(qv), .ready_i(qr), .data_o(qw)
  );

  logic bv_ok;
  assign bv_ok = qv;

  pls_back #(.FracBits(CoordFracBits)) u_back (
    .clk_i, .rst_ni,
    .valid_i(bv_ok), .ready_o(qr), .work_i(qw),
    .light_i(light_q),
    .valid_o(out_valid_o), .stall_i(out_stall_i),
    .red_o(out_red_o), .green_o(out_green_o), .blue_o(out_blue_o)
  );
endmodule

@@ rtl/core/pls_front.sv @@
module pls_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 stall_o,
  input  logic signed [31:0]   lx_i,
  input  logic signed [31:0]   ly_i,
  input  logic signed [31:0]   lz_i,
  input  logic [63:0]          cutoff_i,
  input  logic                 use_dom_i,
  input  logic signed [31:0]   px_i,
  input  logic signed [31:0]   py_i,
  input  logic signed [31:0]   pz_i,
  input  logic signed [15:0]   nx_i,
  input  logic signed [15:0]   ny_i,
  input  logic signed [15:0]   nz_i,
  input  logic                 dom_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output pls_pkg::work_t       work_o
);
  import pls_pkg::*;

  // Stage 1: deltas and domain test.
  logic               v1_q;
  logic signed [32:0] dx_q, dy_q, dz_q;
  logic signed [15:0] nx_q, ny_q, nz_q;
  logic               miss_q;
  // Stage 2: squares and products.
  logic               v2_q, miss2_q;
  logic [65:0]        sx_q, sy_q, sz_q;
  logic signed [49:0] px_q, py_q, pz_q;
  // Stage 3: sums, compare.
  logic               v3_q;
  work_t              w3_q;

  logic adv;
  assign adv = !(v3_q && !ready_i);
  assign stall_o = !adv;

  logic [32:0] ax, ay, az;
  assign ax = dx_q[32] ? 33'(-dx_q) : 33'(dx_q);
  assign ay = dy_q[32] ? 33'(-dy_q) : 33'(dy_q);
  assign az = dz_q[32] ? 33'(-dz_q) : 33'(dz_q);

  logic [66:0] sqs;
  logic [63:0] sq;
  logic signed [51:0] num;
  kind_e kind;
  always_comb begin
    sqs = 67'(sx_q) + 67'(sy_q) + 67'(sz_q);
    sq = (sqs[66:64] != 3'd0) ? '1 : sqs[63:0];
    num = 52'(px_q) + 52'(py_q) + 52'(pz_q);
    if (miss2_q || cutoff_i <= sq) begin
      kind = KindBlack;
    end else if (sq == 64'd0) begin
      kind = KindFull;
    end else begin
      kind = KindLit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q <= 33'(lx_i) - 33'(px_i);
      dy_q <= 33'(ly_i) - 33'(py_i);
      dz_q <= 33'(lz_i) - 33'(pz_i);
      nx_q <= nx_i;
      ny_q <= ny_i;
      nz_q <= nz_i;
      miss_q <= use_dom_i && !dom_i;
      sx_q <= 66'(ax) * 66'(ax);
      sy_q <= 66'(ay) * 66'(ay);
      sz_q <= 66'(az) * 66'(az);
      px_q <= 50'(dx_q) * 50'(nx_q);
      py_q <= 50'(dy_q) * 50'(ny_q);
      pz_q <= 50'(dz_q) * 50'(nz_q);
      miss2_q <= miss_q;
      w3_q.kind <= kind;
      w3_q.sq <= sq;
      w3_q.num <= (num > 0) ? num[48:0] : '0;
    end
  end

  assign valid_o = v3_q;
  assign work_o = w3_q;
endmodule

@@ rtl/core/pls_fifo.sv @@
module pls_fifo #(
  parameter int unsigned Depth = pls_pkg::FifoDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  pls_pkg::work_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output pls_pkg::work_t data_o
);
  import pls_pkg::*;
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  work_t           mem_q [Depth];
  logic [Aw-1:0]   wp_q, rp_q;
  logic [Aw:0]     cnt_q;
  logic            push, pop;

  assign ready_o = cnt_q != (Aw+1)'(Depth);
  assign valid_o = cnt_q != '0;
  assign push = valid_i && ready_o;
  assign pop = valid_o && ready_i;
  assign data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == Aw'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (pop) rp_q <= (rp_q == Aw'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (Aw+1)'(push) - (Aw+1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= data_i;
  end
endmodule

@@ rtl/core/pls_back.sv @@
module pls_back #(
  parameter int unsigned FracBits = pls_pkg::CoordFracBits
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  pls_pkg::work_t  work_i,
  input  pls_pkg::light_t light_i,
  output logic            valid_o,
  input  logic            stall_i,
  output logic [7:0]      red_o,
  output logic [7:0]      green_o,
  output logic [7:0]      blue_o
);
  import pls_pkg::*;
  `include "point_light_shading_factor_unit_macros.svh"

  // Pipeline: 32 sqrt stages, then 64 divider stages computing two quotients in
  // lockstep (dot and inv) with a shared divisor, then blend and scale stages.
  localparam int unsigned SqS = 32;
  localparam int unsigned DvS = 64;
  localparam int unsigned Tot = SqS + DvS + 4;

  logic adv;
  logic [Tot-1:0] v_q;
  assign adv = !(v_q[Tot-1] && stall_i);
  assign ready_o = adv;

  // Square root, one result bit per stage. Each stage carries the operand,
  // the partial remainder and the partial root.
  logic [63:0] sr_x_q [SqS+1];
  logic [33:0] sr_m_q [SqS+1];
  logic [31:0] sr_r_q [SqS+1];
  kind_e       sk_q   [SqS+1];
  logic [48:0] sn_q   [SqS+1];

  always_comb begin
    sr_x_q[0] = work_i.sq;
    sr_m_q[0] = '0;
    sr_r_q[0] = '0;
    sk_q[0] = work_i.kind;
    sn_q[0] = work_i.num;
  end

  for (genvar g = 0; g < SqS; g++) begin : g_sqrt
    logic [35:0] rem_sh;
    logic [36:0] t;
    always_comb begin
      rem_sh = {sr_m_q[g], sr_x_q[g][63-2*g -: 2]};
      t = {1'b0, rem_sh} - {3'b000, sr_r_q[g], 2'b01};
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (!t[36]) begin
          sr_m_q[g+1] <= t[33:0];
          sr_r_q[g+1] <= {sr_r_q[g][30:0], 1'b1};
        end else begin
          sr_m_q[g+1] <= rem_sh[33:0];
          sr_r_q[g+1] <= {sr_r_q[g][30:0], 1'b0};
        end
        sr_x_q[g+1] <= sr_x_q[g];
        sk_q[g+1] <= sk_q[g];
        sn_q[g+1] <= sn_q[g];
      end
    end
  end

  // Long division: dot = num/dist, inv = (I<<F)/dist, one bit per stage.
  localparam int unsigned NumW = 64;
  logic [31:0] dv_d_q [DvS+1];
  logic [63:0] dv_a_q [DvS+1];
  logic [63:0] dv_b_q [DvS+1];
  logic [32:0] ra_q   [DvS+1];
  logic [32:0] rb_q   [DvS+1];
  logic [63:0] qa_q   [DvS+1];
  logic [63:0] qb_q   [DvS+1];
  kind_e       dk_q   [DvS+1];

  always_comb begin
    dv_d_q[0] = sr_r_q[SqS];
    dv_a_q[0] = 64'(sn_q[SqS]);
    dv_b_q[0] = 64'(light_i.intensity) << FracBits;
    ra_q[0] = '0;
    rb_q[0] = '0;
    qa_q[0] = '0;
    qb_q[0] = '0;
    dk_q[0] = sk_q[SqS];
  end

  for (genvar g = 0; g < DvS; g++) begin : g_div
    logic [33:0] ta, tb;
    always_comb begin
      ta = {ra_q[g], dv_a_q[g][NumW-1-g]} - {2'b0, dv_d_q[g]};
      tb = {rb_q[g], dv_b_q[g][NumW-1-g]} - {2'b0, dv_d_q[g]};
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_d_q[g+1] <= dv_d_q[g];
        dv_a_q[g+1] <= dv_a_q[g];
        dv_b_q[g+1] <= dv_b_q[g];
        dk_q[g+1] <= dk_q[g];
        ra_q[g+1] <= ta[33] ? {ra_q[g][31:0], dv_a_q[g][NumW-1-g]} : ta[32:0];
        rb_q[g+1] <= tb[33] ? {rb_q[g][31:0], dv_b_q[g][NumW-1-g]} : tb[32:0];
        qa_q[g+1] <= {qa_q[g][62:0], !ta[33]};
        qb_q[g+1] <= {qb_q[g][62:0], !tb[33]};
      end
    end
  end

  // Stage A: clamps and hard product.
  logic [20:0] dot_c;
  logic [38:0] inv_c;
  logic [24:0] soft_c;
  assign dot_c = (qa_q[DvS] > 64'(1 << 20)) ? 21'(1 << 20) : qa_q[DvS][20:0];
  assign inv_c = (qb_q[DvS] > (64'd1 << 38)) ? (39'd1 << 38) : qb_q[DvS][38:0];
  assign soft_c = (qb_q[DvS] > 64'(1 << 24)) ? 25'(1 << 24) : qb_q[DvS][24:0];

  logic [59:0] hp_q;
  logic [24:0] sa_q;
  logic [24:0] fac_q;
  logic [16:0] s_c;
  kind_e ka_q, kb_q, kc_q;
  logic [45:0] hs;
  logic [24:0] hc;
  logic [42:0] fsum;
  assign s_c = (light_i.softness > 17'd65536) ? 17'd65536 : light_i.softness;
  assign hs = 46'(hp_q >> 14);
  assign hc = (hs > 46'(1 << 24)) ? 25'(1 << 24) : hs[24:0];
  logic [41:0] m1_q, m2_q;
  assign fsum = 43'(m1_q) + 43'(m2_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hp_q <= 60'(inv_c) * 60'(dot_c);
      sa_q <= soft_c;
      ka_q <= dk_q[DvS];
      kb_q <= ka_q;
      m1_q <= 42'(hc) * 42'(17'd65536 - s_c);
      m2_q <= 42'(sa_q) * 42'(s_c);
      kc_q <= kb_q;
      fac_q <= 25'(fsum >> 16);
    end
  end

  // Final stage: scale and saturate, into the output register.
  logic [32:0] cr, cg, cb;
  assign cr = 33'(light_i.color[23:16]) * 33'(fac_q);
  assign cg = 33'(light_i.color[15:8]) * 33'(fac_q);
  assign cb = 33'(light_i.color[7:0]) * 33'(fac_q);

  function automatic logic [7:0] sat(input logic [32:0] p);
    sat = (p[32:16] > 17'd255) ? ChanMax : p[23:16];
  endfunction

  logic [7:0] r_q, gr_q, b_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      case (kc_q)
        KindBlack: begin r_q <= '0; gr_q <= '0; b_q <= '0; end
        KindFull: begin
          r_q <= light_i.color[23:16];
          gr_q <= light_i.color[15:8];
          b_q <= light_i.color[7:0];
        end
        default: begin r_q <= sat(cr); gr_q <= sat(cg); b_q <= sat(cb); end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[Tot-2:0], valid_i};
    end
  end

  assign valid_o = v_q[Tot-1];
  assign red_o = r_q;
  assign green_o = gr_q;
  assign blue_o = b_q;

  `PLS_ASSERT_NXT(a_hold, clk_i, rst_ni, valid_o && stall_i, valid_o && $stable(red_o))
  `PLS_ASSERT_IMP(a_rdy, clk_i, rst_ni, !stall_i, ready_o)
  `PLS_ASSERT_NXT(a_shift, clk_i, rst_ni, adv && v_q[0], v_q[1])
endmodule

@@ test/point_light_shading_factor_unit_tb.sv @@
module point_light_shading_factor_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pls_pkg::*;

  // The watchdog limit covers the worst case: the pipe latency, the
  // longest stall per beat, and the quiet period before each register write.
  localparam int unsigned DrainCycles = 150;
  localparam int unsigned StuckLimit  = 4000;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned BeatsPerPhase = 210;

  // One expected output pixel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // Shading predictor and the store of expected pixels. It keeps its own
  // copy of the light registers and mirrors every write made to the block.
  class shade_scoreboard;
    longint            pos_x, pos_y, pos_z;
    longint unsigned   intensity, cutoff, soft_w, color;
    bit                domains_on;
    rgb_t              pending_rgb[$];
    int unsigned       mismatches;

    function new();
      pos_x = 0; pos_y = 0; pos_z = 0;
      intensity = 65536;
      cutoff = 64'd16711680;
      soft_w = 0;
      color = 24'hFFFFFF;
      domains_on = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] data);
      case (idx)
        RegPosX:      pos_x = longint'(signed'(data[31:0]));
        RegPosY:      pos_y = longint'(signed'(data[31:0]));
        RegPosZ:      pos_z = longint'(signed'(data[31:0]));
        RegIntensity: intensity = 64'(data[31:0]);
        RegCutoff:    cutoff = data;
        RegSoftness:  soft_w = 64'(data[16:0]);
        RegColor:     color = 64'(data[23:0]);
        RegDomains:   domains_on = data[0];
        default: ;
      endcase
    endfunction

    // Floor of the square root, built one result bit at a time.
    function longint unsigned root_floor(longint unsigned x);
      longint unsigned r, t;
      r = 0;
      for (int i = 31; i >= 0; i--) begin
        t = r | (64'd1 << i);
        if (t * t <= x) r = t;
      end
      return r;
    endfunction

    function longint unsigned mag_sq(longint d);
      longint unsigned a;
      a = (d < 0) ? longint'(-d) : longint'(d);
      return a * a;
    endfunction

    function longint unsigned clamp_to(longint unsigned v, longint unsigned lim);
      return (v < lim) ? v : lim;
    endfunction

    // Predicts the pixel for one accepted input beat.
    function void note_point(logic signed [31:0] px, logic signed [31:0] py,
                             logic signed [31:0] pz, logic signed [15:0] nx,
                             logic signed [15:0] ny, logic signed [15:0] nz,
                             logic dom);
      longint dx, dy, dz, num;
      logic [64:0] acc;
      longint unsigned sq, root_d, dot, inv, hard, soft_f, s, fac;
      longint unsigned cr, cg, cb;
      rgb_t px_out;
      dx = pos_x - longint'(px);
      dy = pos_y - longint'(py);
      dz = pos_z - longint'(pz);
      cr = (color >> 16) & 8'hFF;
      cg = (color >> 8) & 8'hFF;
      cb = color & 8'hFF;
      // The squared length saturates instead of wrapping.
      acc = {1'b0, mag_sq(dx)} + {1'b0, mag_sq(dy)};
      if (acc[64]) acc = {1'b0, {64{1'b1}}};
      acc = {1'b0, acc[63:0]} + {1'b0, mag_sq(dz)};
      if (acc[64]) acc = {1'b0, {64{1'b1}}};
      sq = acc[63:0];
      if ((domains_on && !dom) || cutoff <= sq) begin
        px_out = '0;
      end else if (sq == 0) begin
        px_out = {cr[7:0], cg[7:0], cb[7:0]};
      end else begin
        root_d = root_floor(sq);
        num = dx * longint'(nx) + dy * longint'(ny) + dz * longint'(nz);
        dot = (num > 0) ? longint'(num) / root_d : 0;
        dot = clamp_to(dot, 64'd1 << 20);
        inv = (intensity << CoordFracBits) / root_d;
        hard = (clamp_to(inv, 64'd1 << 38) * dot) >> 14;
        hard = clamp_to(hard, 64'd1 << 24);
        soft_f = clamp_to(inv, 64'd1 << 24);
        // Softness beyond one acts as fully soft.
        s = clamp_to(soft_w, 65536);
        fac = (hard * (65536 - s) + soft_f * s) >> 16;
        px_out.red   = 8'(clamp_to((cr * fac) >> 16, 255));
        px_out.green = 8'(clamp_to((cg * fac) >> 16, 255));
        px_out.blue  = 8'(clamp_to((cb * fac) >> 16, 255));
      end
      pending_rgb.push_back(px_out);
    endfunction

    function void check_pixel(rgb_t got);
      rgb_t want;
      if (pending_rgb.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: pixel %h arrived with nothing expected", got);
        return;
      end
      want = pending_rgb.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue)
      begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: pixel mismatch, expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                   want.red, want.green, want.blue, got.red, got.green, got.blue);
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [2:0]         cfg_idx_i;
  logic [63:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic signed [31:0] point_x_i, point_y_i, point_z_i;
  logic signed [15:0] normal_x_i, normal_y_i, normal_z_i;
  logic               in_domain_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [7:0]         out_red_o, out_green_o, out_blue_o;

  shade_scoreboard sb;
  // When set, both sides run flat out with no idle cycles.
  bit                 no_gaps;
  int unsigned        stuck_cycles = 0;

  point_light_shading_factor_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .point_x_i   (point_x_i),
    .point_y_i   (point_y_i),
    .point_z_i   (point_z_i),
    .normal_x_i  (normal_x_i),
    .normal_y_i  (normal_y_i),
    .normal_z_i  (normal_z_i),
    .in_domain_i (in_domain_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Watchdog: any cycle that moves a beat on either side resets the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= StuckLimit) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Output side: for each pixel, stall a random number of cycles, then take
  // the next valid beat and hand it to the scoreboard at the rising edge.
  initial begin
    int unsigned hold;
    forever begin
      hold = no_gaps ? 0 : $urandom_range(0, 13);
      @(negedge clk_i);
      if (hold > 0) begin
        out_stall_i = 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_pixel({out_red_o, out_green_o, out_blue_o});
    end
  end

  // Sends one input beat after a random gap and waits until it is taken.
  // The valid is only lowered when a gap is actually inserted, so
  // back-to-back beats keep it high.
  task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                            logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                            logic dom);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 13);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    point_x_i = px;
    point_y_i = py;
    point_z_i = pz;
    normal_x_i = nx;
    normal_y_i = ny;
    normal_z_i = nz;
    in_domain_i = dom;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_point(px, py, pz, nx, ny, nz, dom);
  endtask

  // Lets the pipe drain completely so a register can be changed safely.
  task automatic drain_pipe();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending_rgb.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.set_reg(idx, data);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // A coordinate near the light, with a random number of significant bits
  // so that the squared distance spans everything from zero to overflow.
  function automatic logic [31:0] near_coord(longint center);
    int unsigned bits;
    longint off;
    bits = $urandom_range(0, 32);
    off = (bits == 0) ? 0 : longint'($urandom) & ((64'd1 << bits) - 1);
    if ($urandom_range(0, 1)) off = -off;
    return 32'(center + off);
  endfunction

  // A normal that is mostly unit-like but sometimes anything in range.
  function automatic logic [15:0] rand_normal();
    if ($urandom_range(0, 3) == 0) return 16'($urandom);
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  initial begin
    logic [63:0] cutoff_pick, intens_pick, soft_pick, color_pick;
    sb = new();
    no_gaps = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = RegPosX;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    out_stall_i = 1'b0;
    point_x_i = '0;
    point_y_i = '0;
    point_z_i = '0;
    normal_x_i = '0;
    normal_y_i = '0;
    normal_z_i = '0;
    in_domain_i = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed beats under the reset settings: light at the origin with a
    // tiny cutoff. A point on the light gives the full color, one LSB away
    // is lit, and a normal facing away gives no hard light.
    send_point(0, 0, 0, 0, 0, 0, 1'b0);
    send_point(1, 0, 0, 16'hC000, 0, 0, 1'b1);
    send_point(1, 0, 0, 16'h4000, 0, 0, 1'b0);
    send_point(0, 32'hFFFFFFFF, 0, 0, 16'h4000, 0, 1'b1);
    send_point(0, 0, 32'd200, 16'h7FFF, 16'h8000, 16'hC000, 1'b0);
    send_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'h7FFF, 16'h7FFF,
               16'h7FFF, 1'b1);
    send_point(32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 16'h8000,
               16'h8000, 1'b0);
    drain_pipe();

    // Light in a far corner, the largest cutoff, extreme intensity: the
    // squared distance to the opposite corner saturates and stays black.
    write_reg(RegPosX, 64'h0000_0000_8000_0000);
    write_reg(RegPosY, 64'h0000_0000_7FFF_FFFF);
    write_reg(RegPosZ, 64'h0000_0000_8000_0000);
    write_reg(RegIntensity, 64'h0000_0000_FFFF_FFFF);
    write_reg(RegCutoff, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(RegSoftness, 64'd131071);
    write_reg(RegColor, 64'h00FF_8001);
    write_reg(RegDomains, 64'd1);
    send_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 1'b1);
    send_point(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 1'b1);
    send_point(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 1'b0);
    send_point(32'h80010000, 32'h7FFFFFFF, 32'h80000000, 16'h8000, 0, 0, 1'b1);
    send_point(32'h80000100, 32'h7FFF0000, 32'h80000000, 16'h4000, 16'h4000, 0, 1'b1);
    send_point(32'h90000000, 32'h70000000, 32'h90000000, 16'hC000, 16'h3000,
               16'hC000, 1'b1);
    drain_pipe();

    // A zero cutoff blacks out even a point sitting on the light.
    write_reg(RegCutoff, 64'd0);
    write_reg(RegSoftness, 64'd65536);
    send_point(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0, 0, 0, 1'b1);
    send_point(32'h80000001, 32'h7FFFFFFF, 32'h80000000, 16'h7FFF, 0, 0, 1'b1);
    drain_pipe();

    // Random phases, each under its own light setting. Most beats land near
    // the light so they get past the cutoff; the rest are anywhere.
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph % 4)
        0: cutoff_pick = 64'hFFFF_FFFF_FFFF_FFFF;
        1: cutoff_pick = rand64();
        2: cutoff_pick = 64'd1 << $urandom_range(20, 63);
        default: cutoff_pick = 64'd16711680;
      endcase
      case ($urandom_range(0, 4))
        0: intens_pick = 0;
        1: intens_pick = 65536;
        2: intens_pick = 64'hFFFF_FFFF;
        3: intens_pick = $urandom_range(0, 1 << 20);
        default: intens_pick = $urandom;
      endcase
      case ($urandom_range(0, 3))
        0: soft_pick = 0;
        1: soft_pick = 65536;
        2: soft_pick = 131071;
        default: soft_pick = $urandom_range(0, 131071);
      endcase
      color_pick = (ph == 0) ? 64'hFF_FFFF : (ph == 1) ? 64'h0 : $urandom_range(0, 24'hFFFFFF);
      write_reg(RegPosX, $urandom);
      write_reg(RegPosY, $urandom);
      write_reg(RegPosZ, (ph == 2) ? 64'h8000_0000 : $urandom);
      write_reg(RegIntensity, intens_pick);
      write_reg(RegCutoff, cutoff_pick);
      write_reg(RegSoftness, soft_pick);
      write_reg(RegColor, color_pick);
      write_reg(RegDomains, ph % 2);
      for (int n = 0; n < BeatsPerPhase; n++) begin
        // Stretches without any idle cycles on either side.
        if (n % 50 == 0) no_gaps = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 6) == 0)
          send_point($urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom_range(0, 1));
        else
          send_point(near_coord(sb.pos_x), near_coord(sb.pos_y), near_coord(sb.pos_z),
                     rand_normal(), rand_normal(), rand_normal(),
                     $urandom_range(0, 4) != 0);
      end
      no_gaps = 0;
      drain_pipe();
    end

    if (sb.mismatches == 0 && sb.pending_rgb.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
